>>> rtl/skhtp_pkg.sv
// Shared types, constants and helper functions for the string-key hash table.
// Used by the front end, queue, table engine and top level; depends on nothing.
package skhtp_pkg;

  localparam int TABLE_ENTRIES = 256;
  localparam int IDX_W         = $clog2(TABLE_ENTRIES);
  localparam int CNT_W         = IDX_W + 1;
  localparam int KEY_BYTES     = 16;
  localparam int PROBE_LIMIT   = TABLE_ENTRIES + 64;
  localparam int PROBE_W       = $clog2(PROBE_LIMIT + 1);
  localparam logic [19:0] HASH_MULT = 20'd1000003;

  localparam logic [1:0] MODE_SET    = 2'd0;
  localparam logic [1:0] MODE_GET    = 2'd1;
  localparam logic [1:0] MODE_REMOVE = 2'd2;
  localparam logic [1:0] MODE_CLEAR  = 2'd3;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_BAD  = 2'd1;
  localparam logic [1:0] ST_FULL = 2'd2;

  localparam logic [1:0] SLOT_EMPTY = 2'd0;
  localparam logic [1:0] SLOT_LIVE  = 2'd1;
  localparam logic [1:0] SLOT_TOMB  = 2'd2;

  // Classified item handed from the front end to the table engine.
  typedef struct packed {
    logic [1:0]  mode;
    logic        bad;
    logic [63:0] hash;
    logic [63:0] key_lo;
    logic [63:0] key_hi;
    logic [3:0]  key_len;
    logic [31:0] value;
  } work_t;

  // One slot of the table memory.
  typedef struct packed {
    logic [63:0] hash;
    logic [63:0] key_lo;
    logic [63:0] key_hi;
    logic [3:0]  key_len;
    logic [31:0] value;
  } slot_t;

  function automatic logic [63:0] low_mask(input logic [4:0] len);
    logic [63:0] m;
    if (len >= 5'd8) m = '1;
    else m = (64'd1 << {len[2:0], 3'b000}) - 64'd1;
    return m;
  endfunction

  function automatic logic [63:0] high_mask(input logic [4:0] len);
    logic [63:0] m;
    if (len <= 5'd8) m = '0;
    else if (len >= 5'd16) m = '1;
    else m = (64'd1 << {len[2:0], 3'b000}) - 64'd1;
    return m;
  endfunction

  function automatic logic [63:0] sext_byte(input logic [7:0] b);
    return {{56{b[7]}}, b};
  endfunction

endpackage

>>> rtl/skhtp_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module skhtp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end

endmodule

>>> rtl/skhtp_front.sv
// Front end: accepts items, checks arguments, hashes the key one byte a cycle.
// Depends on skhtp_pkg.
module skhtp_front import skhtp_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  output logic        full,
  input  logic [1:0]  mode,
  input  logic [63:0] key_low_bytes,
  input  logic [63:0] key_high_bytes,
  input  logic [4:0]  key_length,
  input  logic [31:0] value_in,
  output logic        wq_push,
  input  logic        wq_full,
  output work_t       wq_data
);

  typedef enum logic [2:0] {
    F_IDLE = 3'b001,
    F_HASH = 3'b010,
    F_SEND = 3'b100
  } fstate_t;

  fstate_t     state;
  work_t       item;
  logic [4:0]  cnt;
  logic [127:0] key_all;
  logic [7:0]  cur_byte;
  logic [63:0] prod_lo;
  logic [31:0] prod_hi;
  logic [63:0] in_lo_m;
  logic        in_bad;

  assign full    = (state != F_IDLE);
  assign wq_push = (state == F_SEND) && !wq_full;
  assign wq_data = item;

  assign key_all  = {item.key_hi, item.key_lo};
  assign cur_byte = key_all[{cnt[3:0], 3'b000} +: 8];
  // h * M split into two 32-bit halves; only the low 32 bits of the upper product matter
  assign prod_lo  = item.hash[31:0] * {12'd0, HASH_MULT};
  assign prod_hi  = 32'(item.hash[63:32] * {12'd0, HASH_MULT});

  assign in_lo_m = key_low_bytes & low_mask(key_length);
  assign in_bad  = (key_length >= 5'(KEY_BYTES)) || (mode == MODE_SET && value_in == 32'd0);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= F_IDLE;
    end else begin
      case (state)
        F_IDLE: begin
          if (push) begin
            item.mode    <= mode;
            item.bad     <= in_bad;
            item.key_lo  <= in_lo_m;
            item.key_hi  <= key_high_bytes & high_mask(key_length);
            item.key_len <= key_length[3:0];
            item.value   <= value_in;
            item.hash    <= (key_length != 5'd0) ? (sext_byte(in_lo_m[7:0]) << 7) : 64'd0;
            cnt          <= 5'd0;
            state        <= (mode == MODE_CLEAR || in_bad) ? F_SEND : F_HASH;
          end
        end
        F_HASH: begin
          if (cnt == {1'b0, item.key_len}) begin
            item.hash <= item.hash ^ {59'd0, cnt};
            state     <= F_SEND;
          end else begin
            item.hash <= (prod_lo + {prod_hi, 32'd0}) ^ sext_byte(cur_byte);
            cnt       <= cnt + 5'd1;
          end
        end
        F_SEND: begin
          if (!wq_full) state <= F_IDLE;
        end
        default: state <= F_IDLE;
      endcase
    end
  end

endmodule

>>> rtl/skhtp_queue.sv
// Two-entry queue of classified items between the front end and the table engine.
// Depends on skhtp_pkg.
module skhtp_queue import skhtp_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  wr,
  input  work_t wdata,
  output logic  qfull,
  input  logic  rd,
  output logic  qempty,
  output work_t rdata
);

  work_t      ent [2];
  logic       wptr;
  logic       rptr;
  logic [1:0] count;

  assign qfull  = (count == 2'd2);
  assign qempty = (count == 2'd0);
  assign rdata  = ent[rptr];

  always_ff @(posedge clk) begin
    if (wr) ent[wptr] <= wdata;
    if (rst) begin
      wptr  <= 1'b0;
      rptr  <= 1'b0;
      count <= 2'd0;
    end else begin
      if (wr) wptr <= ~wptr;
      if (rd) rptr <= ~rptr;
      count <= count + {1'b0, wr} - {1'b0, rd};
    end
  end

endmodule

>>> rtl/skhtp_back.sv
// Table engine: walks the probe sequence, updates slots and counts, holds the result.
// Depends on skhtp_pkg and skhtp_ram.
module skhtp_back import skhtp_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        wq_empty,
  input  work_t       wq_data,
  output logic        wq_pop,
  output logic        empty,
  input  logic        pop,
  output logic [1:0]  status,
  output logic        found,
  output logic [31:0] value_out
);

  typedef enum logic [4:0] {
    B_IDLE  = 5'b00001,
    B_READ  = 5'b00010,
    B_PROBE = 5'b00100,
    B_SWEEP = 5'b01000,
    B_OUT   = 5'b10000
  } bstate_t;

  bstate_t             state;
  work_t               item;
  logic [IDX_W-1:0]    idx;
  logic [63:0]         perturb;
  logic [PROBE_W-1:0]  n;
  logic                free_v;
  logic [IDX_W-1:0]    free_idx;
  logic                sweep_reply;
  logic [CNT_W-1:0]    live_count;
  logic [CNT_W-1:0]    tombstone_count;
  logic [1:0]          res_status;
  logic                res_found;
  logic [31:0]         res_value;
  logic                out_valid;

  logic                ram_we;
  logic [IDX_W-1:0]    ram_waddr;
  slot_t               ram_wdata;
  slot_t               ram_rdata;
  logic                st_we;
  logic [IDX_W-1:0]    st_waddr;
  logic [1:0]          st_wdata;
  logic [1:0]          st_rdata;
  logic [IDX_W-1:0]    idx_next;
  logic                at_limit;
  logic                match;
  logic                hit;
  logic                probe_end;
  logic [CNT_W+1:0]    used_sum;
  logic [CNT_W+1:0]    used_x3;
  logic                over_load;

  assign wq_pop    = (state == B_IDLE) && !wq_empty;
  assign empty     = !out_valid;
  assign idx_next  = idx + {idx[IDX_W-3:0], 2'b00} + perturb[IDX_W-1:0] + IDX_W'(1);
  assign at_limit  = (n == PROBE_W'(PROBE_LIMIT));
  assign match     = (ram_rdata.hash == item.hash) && (ram_rdata.key_len == item.key_len)
                  && (ram_rdata.key_lo == item.key_lo) && (ram_rdata.key_hi == item.key_hi);
  assign hit       = !at_limit && (st_rdata == SLOT_LIVE) && match;
  assign probe_end = at_limit || (st_rdata == SLOT_EMPTY);
  assign used_sum  = (CNT_W+2)'(live_count) + (CNT_W+2)'(tombstone_count) + (CNT_W+2)'(1);
  assign used_x3   = used_sum + (used_sum << 1);
  assign over_load = used_x3 > (CNT_W+2)'(2 * TABLE_ENTRIES);

  assign ram_wdata.hash    = item.hash;
  assign ram_wdata.key_lo  = item.key_lo;
  assign ram_wdata.key_hi  = item.key_hi;
  assign ram_wdata.key_len = item.key_len;
  assign ram_wdata.value   = item.value;

  always_comb begin
    ram_we   = 1'b0;
    ram_waddr = idx;
    st_we    = 1'b0;
    st_waddr = idx;
    st_wdata = SLOT_LIVE;
    if (state == B_SWEEP) begin
      st_we    = 1'b1;
      st_wdata = SLOT_EMPTY;
    end else if (state == B_PROBE) begin
      if (hit) begin
        if (item.mode == MODE_SET) ram_we = 1'b1;
        if (item.mode == MODE_REMOVE) begin
          st_we    = 1'b1;
          st_wdata = SLOT_TOMB;
        end
      end else if (probe_end && item.mode == MODE_SET) begin
        if (free_v) begin
          // reuse the first tombstone on the path
          ram_we    = 1'b1;
          ram_waddr = free_idx;
          st_we     = 1'b1;
          st_waddr  = free_idx;
        end else if (!at_limit && !over_load) begin
          ram_we = 1'b1;
          st_we  = 1'b1;
        end
      end
    end
  end

  skhtp_ram #(.WIDTH($bits(slot_t)), .DEPTH(TABLE_ENTRIES)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (idx),
    .rdata (ram_rdata)
  );

  skhtp_ram #(.WIDTH(2), .DEPTH(TABLE_ENTRIES)) u_state (
    .clk   (clk),
    .we    (st_we),
    .waddr (st_waddr),
    .wdata (st_wdata),
    .raddr (idx),
    .rdata (st_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= B_SWEEP;
      idx             <= '0;
      sweep_reply     <= 1'b0;
      live_count      <= '0;
      tombstone_count <= '0;
      out_valid       <= 1'b0;
    end else begin
      if (state == B_OUT && (!out_valid || pop)) out_valid <= 1'b1;
      else if (pop) out_valid <= 1'b0;
      case (state)
        B_IDLE: begin
          if (!wq_empty) begin
            item       <= wq_data;
            idx        <= (wq_data.mode == MODE_CLEAR) ? '0 : wq_data.hash[IDX_W-1:0];
            perturb    <= wq_data.hash;
            n          <= '0;
            free_v     <= 1'b0;
            res_status <= (wq_data.bad && wq_data.mode != MODE_CLEAR) ? ST_BAD : ST_OK;
            res_found  <= 1'b0;
            res_value  <= 32'd0;
            if (wq_data.mode == MODE_CLEAR) begin
              live_count      <= '0;
              tombstone_count <= '0;
              sweep_reply     <= 1'b1;
              state           <= B_SWEEP;
            end else if (wq_data.bad) begin
              state <= B_OUT;
            end else begin
              state <= B_READ;
            end
          end
        end
        B_READ: begin
          state <= B_PROBE;
        end
        B_PROBE: begin
          if (hit) begin
            res_found <= 1'b1;
            if (item.mode == MODE_GET) res_value <= ram_rdata.value;
            if (item.mode == MODE_REMOVE) begin
              live_count      <= live_count - CNT_W'(1);
              tombstone_count <= tombstone_count + CNT_W'(1);
            end
            state <= B_OUT;
          end else if (probe_end) begin
            // key absent: only set has work left
            if (item.mode == MODE_SET) begin
              if (free_v) begin
                live_count      <= live_count + CNT_W'(1);
                tombstone_count <= tombstone_count - CNT_W'(1);
              end else if (!at_limit && !over_load) begin
                live_count <= live_count + CNT_W'(1);
              end else begin
                res_status <= ST_FULL;
              end
            end
            state <= B_OUT;
          end else begin
            if (st_rdata == SLOT_TOMB && !free_v) begin
              free_v   <= 1'b1;
              free_idx <= idx;
            end
            idx     <= idx_next;
            perturb <= perturb >> 5;
            n       <= n + PROBE_W'(1);
            state   <= B_READ;
          end
        end
        B_SWEEP: begin
          idx <= idx + IDX_W'(1);
          if (idx == IDX_W'(TABLE_ENTRIES - 1)) state <= sweep_reply ? B_OUT : B_IDLE;
        end
        B_OUT: begin
          if (!out_valid || pop) begin
            status    <= res_status;
            found     <= res_found;
            value_out <= res_value;
            state     <= B_IDLE;
          end
        end
        default: state <= B_IDLE;
      endcase
    end
  end

endmodule

>>> rtl/string_key_hash_table_perturb_probe.sv
// Open-addressed hash table from short byte-string keys to 32-bit value handles.
// Top level; depends on skhtp_pkg, skhtp_front, skhtp_queue, skhtp_back.
//
// Input channel: drive mode, key bytes, key_length and value_in with push high;
// the item is taken on a clock edge where full is low. Result channel: while
// empty is low, status/found/value_out show the oldest result; pop takes it.
// One result per item, in order.
// Operation: the front end hashes one key byte a cycle and hands the item to the
// queue after the last byte (clear and rejected items skip hashing); it takes a
// new item only once the last one is in the queue. The table engine reads slot
// state and data through registered RAM ports: each slot on the probe path passes
// a read state and a probe state, and taking the item and posting the result add
// an idle state and an output state. Clear rewrites all 256 slot states.
// Front end and engine work on different items at once through a two-entry queue.
// Reset (synchronous, rst high) runs the same sweep; items taken meanwhile
// wait in the queue. When pop stays low, one result is held, the engine stops
// after its next item, and the queue and front end then fill and raise full.
module string_key_hash_table_perturb_probe import skhtp_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  output logic        full,
  input  logic [1:0]  mode,
  input  logic [63:0] key_low_bytes,
  input  logic [63:0] key_high_bytes,
  input  logic [4:0]  key_length,
  input  logic [31:0] value_in,
  output logic        empty,
  input  logic        pop,
  output logic [1:0]  status,
  output logic        found,
  output logic [31:0] value_out
);

  logic  wq_push;
  logic  wq_full;
  logic  wq_pop;
  logic  wq_empty;
  work_t wq_in;
  work_t wq_out;

  skhtp_front u_front (
    .clk            (clk),
    .rst            (rst),
    .push           (push),
    .full           (full),
    .mode           (mode),
    .key_low_bytes  (key_low_bytes),
    .key_high_bytes (key_high_bytes),
    .key_length     (key_length),
    .value_in       (value_in),
    .wq_push        (wq_push),
    .wq_full        (wq_full),
    .wq_data        (wq_in)
  );

  skhtp_queue u_queue (
    .clk    (clk),
    .rst    (rst),
    .wr     (wq_push),
    .wdata  (wq_in),
    .qfull  (wq_full),
    .rd     (wq_pop),
    .qempty (wq_empty),
    .rdata  (wq_out)
  );

  skhtp_back u_back (
    .clk       (clk),
    .rst       (rst),
    .wq_empty  (wq_empty),
    .wq_data   (wq_out),
    .wq_pop    (wq_pop),
    .empty     (empty),
    .pop       (pop),
    .status    (status),
    .found     (found),
    .value_out (value_out)
  );

endmodule
